@@ rtl/kpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key press classifier package
// Widths, reset values, register indexes and event codes shared by the
// key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

    // Field widths of the scan word and the event word.
    localparam int LEVEL_BITS      = 4;
    localparam int NOW_WIDTH       = 32;
    localparam int EVENT_BITS      = 2;
    localparam int EVENTS_WIDTH    = 8;
    localparam int EVENT_SLOTS     = EVENTS_WIDTH / EVENT_BITS;
    localparam int IN_FIELD_BITS   = LEVEL_BITS + NOW_WIDTH;
    localparam int IN_TDATA_WIDTH  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = EVENTS_WIDTH;

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS   = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLE_CLICK = CFG_INDEX_WIDTH'(1);

    localparam logic [CFG_DATA_WIDTH-1:0] LONG_PRESS_RESET   = CFG_DATA_WIDTH'(1000);
    localparam logic [CFG_DATA_WIDTH-1:0] DOUBLE_CLICK_RESET = CFG_DATA_WIDTH'(300);

    // Default number of tracked keys.
    localparam int NUM_KEYS_DEFAULT = 4;

    // Per-key event codes.
    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } event_code_t;

endpackage : kpc_pkg
`default_nettype wire

@@ rtl/key_press_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: a scan word passes through the input register, then the event register.
// Throughput: one scan word per cycle while the event stream is not stalled; the
// per-key state is read and rewritten between the input register and the event register.
// Reset: asynchronous, active low; all keys idle and released, limits at
// 1000 ms and 300 ms. No clearing pass; the block is ready right after reset.
// ----------------------------------------------------------------------------
// Key press classifier
// Classifies presses of active-low keys as short, long or double click from
// a stream of scan words carrying key levels and a millisecond time stamp.
// ----------------------------------------------------------------------------
module key_press_classifier
#(
    parameter int NUM_KEYS = kpc_pkg::NUM_KEYS_DEFAULT
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // Scan words: [3:0] key_levels, [35:4] now_ms, [39:36] zero.
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [kpc_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,

    // Event words: [7:0] key_events.
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [kpc_pkg::OUT_TDATA_WIDTH-1:0]       m_axis_tdata,

    // Configuration writes.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [kpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [kpc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    import kpc_pkg::*;

    localparam int REPORTED_KEYS = (NUM_KEYS < EVENT_SLOTS) ? NUM_KEYS : EVENT_SLOTS;

    // Configuration registers.
    logic [CFG_DATA_WIDTH-1:0] long_press_reg;
    logic [CFG_DATA_WIDTH-1:0] double_click_reg;

    // Input register.
    logic                  in_valid_reg;
    logic [LEVEL_BITS-1:0] in_levels_reg;
    logic [NOW_WIDTH-1:0]  in_now_reg;

    // Per-key state.
    logic [NUM_KEYS-1:0]   armed_reg;
    logic [NUM_KEYS-1:0]   prev_level_reg;
    logic [NOW_WIDTH-1:0]  press_time_reg [NUM_KEYS];

    // Event register.
    logic                    out_valid_reg;
    logic [EVENTS_WIDTH-1:0] out_events_reg;

    // Next values.
    logic [NUM_KEYS-1:0]     armed_next;
    logic [NUM_KEYS-1:0]     level_vec;
    logic [NUM_KEYS-1:0]     capture_vec;
    logic [NUM_KEYS-1:0]     fire_vec;
    event_code_t             ev_vec [NUM_KEYS];
    logic [EVENTS_WIDTH-1:0] events_next;

    logic s_accept;
    logic out_ready;
    logic advance;

    // Handshake: the input register moves into the event register whenever
    // that register is empty or being drained.
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_events_reg;
    assign cfg_ready     = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg   <= LONG_PRESS_RESET;
            double_click_reg <= DOUBLE_CLICK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS:   long_press_reg   <= cfg_data;
                REG_DOUBLE_CLICK: double_click_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_levels_reg <= s_axis_tdata[LEVEL_BITS-1:0];
            in_now_reg    <= s_axis_tdata[LEVEL_BITS +: NOW_WIDTH];
        end
    end

    // Per-key classification.
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        logic                 level;
        logic                 steady;
        logic                 falling;
        logic [NOW_WIDTH-1:0] elapsed;
        logic                 over_long;
        logic                 under_long;
        logic                 over_double;
        logic                 under_double;
        logic                 key_armed;
        logic                 key_capture;
        event_code_t          key_ev;

        // Keys without a level bit read as pressed.
        if (k < LEVEL_BITS)
        begin : g_level
            assign level = in_levels_reg[k];
        end
        else
        begin : g_pressed
            assign level = 1'b0;
        end

        assign steady       = level && prev_level_reg[k];
        assign falling      = !level && prev_level_reg[k];
        assign elapsed      = in_now_reg - press_time_reg[k];
        assign over_long    = elapsed > NOW_WIDTH'(long_press_reg);
        assign under_long   = elapsed < NOW_WIDTH'(long_press_reg);
        assign over_double  = elapsed > NOW_WIDTH'(double_click_reg);
        assign under_double = elapsed < NOW_WIDTH'(double_click_reg);

        always_comb
        begin
            key_ev      = EV_NONE;
            key_armed   = armed_reg[k];
            key_capture = 1'b0;
            if (!armed_reg[k])
            begin
                if (falling)
                begin
                    key_armed   = 1'b1;
                    key_capture = 1'b1;
                end
            end
            else if (steady && over_long)
            begin
                key_ev    = EV_LONG;
                key_armed = 1'b0;
            end
            else if (falling && under_double)
            begin
                key_ev    = EV_DOUBLE;
                key_armed = 1'b0;
            end
            else if (steady && over_double && under_long)
            begin
                key_ev    = EV_SHORT;
                key_armed = 1'b0;
            end
        end

        assign level_vec[k]   = level;
        assign armed_next[k]  = key_armed;
        assign capture_vec[k] = key_capture;
        assign fire_vec[k]    = (key_ev != EV_NONE);
        assign ev_vec[k]      = key_ev;
    end

    // Pack the codes of the keys that have a slot in the event word.
    always_comb
    begin
        events_next = '0;
        for (int k = 0; k < REPORTED_KEYS; k++)
        begin
            events_next[EVENT_BITS*k +: EVENT_BITS] = ev_vec[k];
        end
    end

    // Per-key control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= '0;
            prev_level_reg <= '1;
        end
        else if (advance)
        begin
            armed_reg      <= armed_next;
            prev_level_reg <= level_vec;
        end
    end

    // Press time stamps, only read while the key is armed.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (advance && capture_vec[k])
            begin
                press_time_reg[k] <= in_now_reg;
            end
        end
    end

    // Event register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Event register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_events_reg <= events_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A key that raises an event is idle afterwards.
    a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> ((armed_reg & $past(fire_vec)) == '0))
        else $error("key still armed after raising an event");

    // Only an armed key raises an event.
    a_fire_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> ((fire_vec & ~armed_reg) == '0))
        else $error("event raised by an idle key");

    // A waiting scan word is neither lost nor overwritten.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_now_reg)
                                        && $stable(in_levels_reg)))
        else $error("pending scan word changed before it was processed");

    // An event word appears only when a scan word moved forward.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("event word without a processed scan word");
`endif

endmodule : key_press_classifier
`default_nettype wire

@@ sim/tb_key_press_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key press classifier testbench
// Streams scan words into the classifier and checks every event word against
// a cycle-free model of the per-key press state. A short directed sequence
// walks through short, long and double clicks, exact limits, late second
// presses and time stamp wrap. Random phases follow under several limit
// settings, with random idling on both streams, one long output stall and a
// full drain before every register write.
// ----------------------------------------------------------------------------
module tb_key_press_classifier;

    import kpc_pkg::*;

    localparam int NUM_KEYS     = NUM_KEYS_DEFAULT;
    localparam int IDLE_PERCENT = 7;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // One scan as it travels in tdata: time stamp above the key levels.
    typedef struct packed {
        logic [NOW_WIDTH-1:0]  now_ms;
        logic [LEVEL_BITS-1:0] levels;
    } scan_t;

    // Press state of all keys.
    typedef struct packed {
        logic [NUM_KEYS-1:0]                armed;
        logic [NUM_KEYS-1:0]                released;
        logic [NUM_KEYS-1:0][NOW_WIDTH-1:0] press_ms;
    } keypad_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0]    s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0]   m_axis_tdata;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]   cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]    cfg_data = '0;

    // Scans waiting to be sent and event words still owed by the block.
    scan_t                        scan_backlog[$];
    logic [EVENTS_WIDTH-1:0]      due_events[$];

    // Key state as the block should hold it, and as the stimulus plans it.
    keypad_t                      tracked_keys;
    keypad_t                      planned_keys;
    logic [CFG_DATA_WIDTH-1:0]    tracked_long_ms = LONG_PRESS_RESET;
    logic [CFG_DATA_WIDTH-1:0]    tracked_double_ms = DOUBLE_CLICK_RESET;
    logic [CFG_DATA_WIDTH-1:0]    plan_long_ms = LONG_PRESS_RESET;
    logic [CFG_DATA_WIDTH-1:0]    plan_double_ms = DOUBLE_CLICK_RESET;
    logic [NOW_WIDTH-1:0]         plan_now = '0;

    logic                         scan_taken = 1'b0;
    logic                         calm = 1'b0;
    int                           stall_requests = 0;
    int                           fail_count = 0;
    int                           cycle_count = 0;

    key_press_classifier uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Advance the key state by one scan and return the event word it raises.
    task automatic classify_scan(inout keypad_t pad,
                                 input logic [LEVEL_BITS-1:0] levels,
                                 input logic [NOW_WIDTH-1:0] now_ms,
                                 input logic [CFG_DATA_WIDTH-1:0] long_ms,
                                 input logic [CFG_DATA_WIDTH-1:0] double_ms,
                                 output logic [EVENTS_WIDTH-1:0] events);
        logic                 level;
        logic                 steady;
        logic                 falling;
        logic [NOW_WIDTH-1:0] elapsed;
        event_code_t          code;
        events = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            // Keys without a level bit read as pressed.
            level   = (k < LEVEL_BITS) ? levels[k] : 1'b0;
            steady  = level && pad.released[k];
            falling = !level && pad.released[k];
            elapsed = now_ms - pad.press_ms[k];
            code    = EV_NONE;
            if (!pad.armed[k])
            begin
                if (falling)
                begin
                    pad.press_ms[k] = now_ms;
                    pad.armed[k]    = 1'b1;
                end
            end
            else if (steady && elapsed > NOW_WIDTH'(long_ms))
            begin
                code = EV_LONG;
            end
            else if (falling && elapsed < NOW_WIDTH'(double_ms))
            begin
                code = EV_DOUBLE;
            end
            else if (steady && elapsed > NOW_WIDTH'(double_ms)
                     && elapsed < NOW_WIDTH'(long_ms))
            begin
                code = EV_SHORT;
            end
            if (code != EV_NONE)
                pad.armed[k] = 1'b0;
            pad.released[k] = level;
            if (k < EVENT_SLOTS)
                events[EVENT_BITS*k +: EVENT_BITS] = code;
        end
    endtask

    // Queue one scan and keep the planned key state in step with it.
    task automatic queue_scan(input logic [LEVEL_BITS-1:0] levels,
                              input logic [NOW_WIDTH-1:0] now_ms);
        scan_t                   item;
        logic [EVENTS_WIDTH-1:0] unused;
        item.levels = levels;
        item.now_ms = now_ms;
        classify_scan(planned_keys, levels, now_ms, plan_long_ms, plan_double_ms, unused);
        plan_now = now_ms;
        scan_backlog.push_back(item);
    endtask

    // Mostly plausible key activity, with hits right on the limits, time
    // jumps and arbitrary level patterns mixed in.
    task automatic queue_random_scans(input int count);
        int                    mode;
        int                    span;
        int                    k;
        logic [LEVEL_BITS-1:0] lv;
        logic [NOW_WIDTH-1:0]  t;
        logic [NOW_WIDTH-1:0]  target;
        for (int i = 0; i < count; i++)
        begin
            span = ((plan_long_ms > plan_double_ms) ? int'(plan_long_ms)
                                                    : int'(plan_double_ms)) + 4;
            mode = $urandom_range(0, 99);
            lv   = planned_keys.released[LEVEL_BITS-1:0];
            for (int b = 0; b < LEVEL_BITS; b++)
                if ($urandom_range(0, 99) < 25)
                    lv[b] = ~lv[b];
            t = plan_now + NOW_WIDTH'($urandom_range(0, span / 2));
            if (mode >= 40 && mode < 75)
            begin
                // Aim one armed key at a limit or just beside it.
                k = $urandom_range(0, NUM_KEYS - 1);
                if (planned_keys.armed[k])
                begin
                    case ($urandom_range(0, 5))
                        0: target = NOW_WIDTH'(plan_double_ms) - 1;
                        1: target = NOW_WIDTH'(plan_double_ms);
                        2: target = NOW_WIDTH'(plan_double_ms) + 1;
                        3: target = NOW_WIDTH'(plan_long_ms) - 1;
                        4: target = NOW_WIDTH'(plan_long_ms);
                        default: target = NOW_WIDTH'(plan_long_ms) + 1;
                    endcase
                    t = planned_keys.press_ms[k] + target;
                    lv[k] = planned_keys.released[k] ? 1'($urandom_range(0, 1)) : 1'b1;
                end
            end
            else if (mode >= 75 && mode < 85)
            begin
                t = $urandom();
            end
            else if (mode >= 85 && mode < 92)
            begin
                lv = LEVEL_BITS'($urandom_range(0, 15));
            end
            else if (mode >= 92)
            begin
                t = plan_now + NOW_WIDTH'($urandom_range(0, 1));
            end
            queue_scan(lv, t);
        end
    endtask

    // Wait until every scan is sent and every event word has come back.
    task automatic wait_drained();
        while (scan_backlog.size() != 0 || s_axis_tvalid || due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                  input logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_LONG_PRESS)
            tracked_long_ms = value;
        else
            tracked_double_ms = value;
    endtask

    // Set both limits on an idle block, then run random scans and drain.
    task automatic run_phase(input logic [CFG_DATA_WIDTH-1:0] long_ms,
                             input logic [CFG_DATA_WIDTH-1:0] double_ms,
                             input int count);
        write_register(REG_LONG_PRESS, long_ms);
        write_register(REG_DOUBLE_CLICK, double_ms);
        @(negedge clk);
        cfg_valid      <= 1'b0;
        plan_long_ms   = long_ms;
        plan_double_ms = double_ms;
        queue_random_scans(count);
        wait_drained();
    endtask

    // Scan word driver: a word stays on the bus until it is taken.
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || scan_taken)
        begin
            if (scan_backlog.size() != 0
                && (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_TDATA_WIDTH'(scan_backlog.pop_front());
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Event word receiver, with random idling and requested long holds.
    always @(negedge clk)
    begin : receiver
        int stall_served;
        int stall_left;
        if (stall_served != stall_requests)
        begin
            stall_served = stall_served + 1;
            stall_left   = HOLD_CYCLES;
        end
        if (stall_left != 0)
        begin
            stall_left    = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Predict on every taken scan word and check every delivered event word.
    always @(posedge clk)
    begin : scoreboard
        scan_t                   seen;
        logic [EVENTS_WIDTH-1:0] events;
        scan_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            seen = scan_t'(s_axis_tdata[LEVEL_BITS+NOW_WIDTH-1:0]);
            classify_scan(tracked_keys, seen.levels, seen.now_ms,
                          tracked_long_ms, tracked_double_ms, events);
            due_events.push_back(events);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_events.size() == 0)
            begin
                $error("key_events: expected no word, got %02h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                events = due_events.pop_front();
                if (m_axis_tdata !== events)
                begin
                    $error("key_events: expected %02h, got %02h", events, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Run time guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        tracked_keys          = '0;
        tracked_keys.released = '1;
        planned_keys          = tracked_keys;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk at the reset limits of 1000 ms and 300 ms.
        queue_scan(4'hF, 32'd100);
        queue_scan(4'hE, 32'd100);         // key 0 pressed
        queue_scan(4'hF, 32'd150);
        queue_scan(4'hF, 32'd400);         // exactly on the double limit
        queue_scan(4'hF, 32'd401);         // short
        queue_scan(4'hD, 32'd500);         // key 1 pressed
        queue_scan(4'hF, 32'd520);
        queue_scan(4'hD, 32'd799);         // double click
        queue_scan(4'hB, 32'd1000);        // key 2 pressed
        queue_scan(4'hF, 32'd1500);
        queue_scan(4'hF, 32'd2000);        // exactly on the long limit
        queue_scan(4'hF, 32'd2001);        // long
        queue_scan(4'h7, 32'd3000);        // key 3 pressed
        queue_scan(4'hF, 32'd3100);
        queue_scan(4'h7, 32'd3300);        // second press too late
        queue_scan(4'h7, 32'd5000);        // still held
        queue_scan(4'hF, 32'd5001);
        queue_scan(4'hF, 32'd5002);        // long from the first press
        queue_scan(4'h0, 32'hFFFF_FFF0);   // all keys pressed just before wrap
        queue_scan(4'hF, 32'hFFFF_FFF8);
        queue_scan(4'hF, 32'h0000_0100);   // elapsed across the wrap
        queue_scan(4'hA, 32'h0000_0120);
        queue_scan(4'hF, 32'h0000_03E0);
        queue_scan(4'hF, 32'h0000_03E0);
        queue_scan(4'hF, 32'hFFFF_FFFF);
        wait_drained();

        run_phase(16'd1000, 16'd300, 80);
        calm = 1'b1;
        run_phase(16'd0, 16'd0, 78);
        calm = 1'b0;
        run_phase(16'd65535, 16'd65535, 78);
        // The receiver holds off while scans keep coming.
        stall_requests = stall_requests + 1;
        run_phase(16'd65535, 16'd0, 78);
        run_phase(16'd0, 16'd65535, 78);
        run_phase(16'd200, 16'd500, 78);   // crossed limits, no short window
        run_phase(16'd50, 16'd20, 78);
        run_phase(16'd3000, 16'd700, 78);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
